// ===== rtl/core/lbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED and buzzer cue sequencer package
// Shared types, register indexes and the fixed cue and note ROM contents.
// ----------------------------------------------------------------------------
package lbcs_pkg;

  localparam int unsigned DepthW  = 16;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned ToneW   = 12;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CueW    = 3;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned NoteW   = 4;
  localparam int unsigned DurW    = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] CfgCommonAnode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRgbPresent  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAmbientPer  = 2'd2;

  localparam logic [CueW-1:0] CueNone  = 3'd0;
  localparam logic [CueW-1:0] CueError = 3'd5;

  localparam logic [PeriodW-1:0] AmbientPerRst = 16'd1000;

  // LED bit positions in the lit-LED vector
  localparam int unsigned LedR = 0;
  localparam int unsigned LedG = 1;
  localparam int unsigned LedB = 2;

  typedef struct packed {
    logic              operation;
    logic [CueW-1:0]   cue;
    logic              online;
    logic [DepthW-1:0] queue_depth;
    logic              clock_ok;
  } item_t;

  typedef struct packed {
    logic             red_pin;
    logic             green_pin;
    logic             blue_pin;
    logic [ToneW-1:0] tone_hz;
    logic             busy_res;
  } res_t;

  typedef struct packed {
    logic               common_anode;
    logic               rgb_present;
    logic [PeriodW-1:0] ambient_period;
  } cfg_t;

  function automatic logic [ToneW-1:0] note_hz(input logic [NoteW-1:0] k);
    logic [ToneW-1:0] hz;
    case (k)
      4'd0:    hz = 12'd1800;
      4'd1:    hz = 12'd2400;
      4'd2:    hz = 12'd600;
      4'd3:    hz = 12'd0;
      4'd4:    hz = 12'd600;
      4'd5:    hz = 12'd1600;
      4'd6:    hz = 12'd1800;
      4'd7:    hz = 12'd2100;
      4'd8:    hz = 12'd0;
      4'd9:    hz = 12'd1400;
      4'd10:   hz = 12'd400;
      default: hz = 12'd0;
    endcase
    return hz;
  endfunction

  function automatic logic [DurW-1:0] note_ms(input logic [NoteW-1:0] k);
    logic [DurW-1:0] ms;
    case (k)
      4'd0:    ms = 9'd70;
      4'd1:    ms = 9'd90;
      4'd2:    ms = 9'd140;
      4'd3:    ms = 9'd60;
      4'd4:    ms = 9'd140;
      4'd5:    ms = 9'd45;
      4'd6:    ms = 9'd70;
      4'd7:    ms = 9'd70;
      4'd8:    ms = 9'd40;
      4'd9:    ms = 9'd90;
      4'd10:   ms = 9'd420;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

  function automatic logic [NoteW-1:0] cue_first(input logic [CueW-1:0] c);
    logic [NoteW-1:0] f;
    case (c)
      3'd2:    f = 4'd2;
      3'd3:    f = 4'd5;
      3'd4:    f = 4'd6;
      3'd5:    f = 4'd10;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  function automatic logic [IdxW-1:0] cue_len(input logic [CueW-1:0] c);
    logic [IdxW-1:0] n;
    case (c)
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd3;
      3'd3:    n = 3'd1;
      3'd4:    n = 3'd4;
      3'd5:    n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Colour bits: bit 0 red, bit 1 green, bit 2 blue
  function automatic logic [2:0] cue_colour(input logic [CueW-1:0] c);
    logic [2:0] col;
    case (c)
      3'd1:    col = 3'b010;
      3'd2:    col = 3'b011;
      3'd4:    col = 3'b100;
      3'd5:    col = 3'b001;
      default: col = 3'b000;
    endcase
    return col;
  endfunction

endpackage

// ===== rtl/core/led_buzzer_cue_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// LED and buzzer cue sequencer, top level
// Sequences LED colours and buzzer notes for status cues and shows an
// ambient health display between cues.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: either a
//   one-millisecond tick or a request to start a cue, together with the
//   current health flags. Output channel (out_valid_o / out_stall_i) returns
//   exactly one result item per input item: LED pin levels, buzzer tone and
//   the busy flag.
//   An accepted item's result is registered in the output stage, or in the
//   skid register under a stall. Throughput is one item per cycle while the
//   receiver does not stall, set by the single-pass state update in the core.
//   When the receiver stalls, the result is held and a second item can still
//   be taken into a skid register; in_stall_o rises only once both are full.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) is to be written only while
//   the block is idle; the block itself does not enforce this. Reset clears all
//   cue and display state, empties the output stage and loads the registers with
//   their defaults: anode common off, no RGB LED, ambient period of 1000 ticks.
// ----------------------------------------------------------------------------
module led_buzzer_cue_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [lbcs_pkg::CueW-1:0]     cue_i,
  input  logic                          online_i,
  input  logic [lbcs_pkg::DepthW-1:0]   queue_depth_i,
  input  logic                          clock_ok_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          red_pin_o,
  output logic                          green_pin_o,
  output logic                          blue_pin_o,
  output logic [lbcs_pkg::ToneW-1:0]    tone_hz_o,
  output logic                          busy_res_o,
  input  logic                          cfg_we_i,
  input  logic [lbcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbcs_pkg::CfgDatW-1:0]  cfg_data_i
);
  import lbcs_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  res;
  res_t  out_q;
  res_t  skid_q;
  logic  out_vq;
  logic  skid_vq;
  logic  in_acc;
  logic  out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.common_anode   <= 1'b0;
      cfg_q.rgb_present    <= 1'b0;
      cfg_q.ambient_period <= AmbientPerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCommonAnode: cfg_q.common_anode   <= cfg_data_i[0];
        CfgRgbPresent:  cfg_q.rgb_present    <= cfg_data_i[0];
        CfgAmbientPer:  cfg_q.ambient_period <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  assign item.operation   = operation_i;
  assign item.cue         = cue_i;
  assign item.online      = online_i;
  assign item.queue_depth = queue_depth_i;
  assign item.clock_ok    = clock_ok_i;

  assign in_acc   = in_valid_i & ~skid_vq;
  assign out_free = ~out_vq | ~out_stall_i;

  lbcs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (out_free) begin
      out_vq  <= skid_vq | in_acc;
      skid_vq <= 1'b0;
    end else if (in_acc) begin
      skid_vq <= 1'b1;
    end
  end

  // The skid entry always goes out first, since it is the older item.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vq) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_vq;
  assign out_valid_o = out_vq;
  assign red_pin_o   = out_q.red_pin;
  assign green_pin_o = out_q.green_pin;
  assign blue_pin_o  = out_q.blue_pin;
  assign tone_hz_o   = out_q.tone_hz;
  assign busy_res_o  = out_q.busy_res;

endmodule

// ===== rtl/core/lbcs_core.sv =====
// ----------------------------------------------------------------------------
// LED and buzzer cue sequencer core
// Holds the cue, timing and display state and works out each item's result
// in a single pass.
// ----------------------------------------------------------------------------
module lbcs_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  lbcs_pkg::item_t item_i,
  input  lbcs_pkg::cfg_t  cfg_i,
  output lbcs_pkg::res_t  res_o
);
  import lbcs_pkg::*;

  logic [CueW-1:0]  active_q, active_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [TimeW-1:0] now1_q, now1_d;
  logic [TimeW-1:0] next_q, next_d;
  logic [TimeW-1:0] last_q, last_d;
  logic             blink_q, blink_d;
  logic [2:0]       led_q, led_d;
  logic [ToneW-1:0] tone_q, tone_d;

  logic [CueW-1:0]  cue_eff;
  logic [NoteW-1:0] note_k;
  logic [TimeW-1:0] since_last;
  logic [2:0]       want;
  logic             set_led;
  logic             blink_n;

  // now1_q holds the time the next tick will bring, so no increment sits
  // ahead of the compares.
  always_comb begin
    cue_eff    = (item_i.cue > CueError) ? CueNone : item_i.cue;
    note_k     = cue_first(active_q) + {1'b0, idx_q};
    since_last = now1_q - last_q;
    blink_n    = ~blink_q;

    active_d = active_q;
    idx_d    = idx_q;
    now1_d   = now1_q;
    next_d   = next_q;
    last_d   = last_q;
    blink_d  = blink_q;
    tone_d   = tone_q;
    want     = 3'b000;
    set_led  = 1'b0;

    if (item_i.operation) begin
      active_d = cue_eff;
      idx_d    = '0;
      next_d   = '0;
      want     = cue_colour(cue_eff);
      set_led  = 1'b1;
    end else begin
      now1_d = now1_q + 32'd1;
      if (active_q != CueNone) begin
        if (now1_q >= next_q) begin
          if (idx_q >= cue_len(active_q)) begin
            active_d = CueNone;
            tone_d   = '0;
            set_led  = 1'b1;
          end else begin
            idx_d  = idx_q + 3'd1;
            tone_d = note_hz(note_k);
            next_d = now1_q + {{(TimeW-DurW){1'b0}}, note_ms(note_k)};
          end
        end
      end else if (since_last >= {{(TimeW-PeriodW){1'b0}}, cfg_i.ambient_period}) begin
        last_d  = now1_q;
        blink_d = blink_n;
        set_led = 1'b1;
        if (!item_i.clock_ok) begin
          want = {2'b00, blink_n};
        end else if (item_i.online && (item_i.queue_depth == '0)) begin
          want = 3'b010;
        end else if (cfg_i.rgb_present) begin
          want = {blink_n, 2'b00};
        end else begin
          want = {2'b00, blink_n};
        end
      end
    end

    led_d = led_q;
    if (set_led) begin
      led_d[LedR] = want[LedR];
      led_d[LedG] = want[LedG];
      // Without a blue channel the blue bit is left as it was.
      if (cfg_i.rgb_present) begin
        led_d[LedB] = want[LedB];
      end
    end

    res_o.red_pin   = led_d[LedR] ^ cfg_i.common_anode;
    res_o.green_pin = led_d[LedG] ^ cfg_i.common_anode;
    res_o.blue_pin  = cfg_i.rgb_present ? (led_d[LedB] ^ cfg_i.common_anode)
                                        : cfg_i.common_anode;
    res_o.tone_hz   = tone_d;
    res_o.busy_res  = (active_d != CueNone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CueNone;
      idx_q    <= '0;
      now1_q   <= 32'd1;
      next_q   <= '0;
      last_q   <= '0;
      blink_q  <= 1'b0;
      led_q    <= '0;
      tone_q   <= '0;
    end else if (acc_i) begin
      active_q <= active_d;
      idx_q    <= idx_d;
      now1_q   <= now1_d;
      next_q   <= next_d;
      last_q   <= last_d;
      blink_q  <= blink_d;
      led_q    <= led_d;
      tone_q   <= tone_d;
    end
  end

endmodule

// ===== rtl/core/lbcs_checker.sv =====
// ----------------------------------------------------------------------------
// LED and buzzer cue sequencer checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module lbcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          red_pin_o,
  input logic                          green_pin_o,
  input logic                          blue_pin_o,
  input logic [lbcs_pkg::ToneW-1:0]    tone_hz_o,
  input logic                          busy_res_o
);
  import lbcs_pkg::*;

  logic [ToneW+3:0] pay;
  assign pay = {red_pin_o, green_pin_o, blue_pin_o, tone_hz_o, busy_res_o};

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pay))
    else $error("stalled result changed");

  // The input side only stalls once a result is waiting.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // The input stall only arises from an output stall.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // A result appears only after an item was taken.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without item");

  // The ROM holds no tone above 2400 Hz.
  a_tone_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tone_hz_o <= 12'd2400)
    else $error("tone out of range");

endmodule

bind led_buzzer_cue_sequencer_top lbcs_checker u_lbcs_checker (.*);
